### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the key chord matcher core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is held
`define KCSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define KCSM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCSM_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/kcsm_pkg.sv
// ----------------------------------------------------------------------------
// kcsm_pkg
// types and constants of the key chord sequence matcher
// ----------------------------------------------------------------------------
package kcsm_pkg;

    localparam int KEY_SLOTS = 3;
    localparam int CODE_W    = 21;
    localparam int TYPE_W    = 2;
    localparam int CMD_W     = 16;
    localparam int LEN_W     = 2;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;

    localparam logic [MODE_W-1:0] MODE_KEY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]            cmd_id;
        logic [LEN_W-1:0]            len;
        logic [KEY_SLOTS*TYPE_W-1:0] types;
        logic [KEY_SLOTS*CODE_W-1:0] codes;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic                load;
        logic                add_wr;
        logic                set_st;
        logic [STATUS_W-1:0] st;
        logic                push_key;
        logic                scan_start;
        logic                scan_rd;
        logic                scan_eval;
        logic                sh_start;
        logic                sh_rd;
        logic                sh_wr;
        logic                sh_done;
        logic                post;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              len_ok;
        logic              full;
        logic              empty;
        logic              issue_done;
        logic              hit;
        logic              miss_end;
        logic              sh_last;
        logic              out_free;
    } dp_sts_t;

endpackage

### hw/rtl/key_chord_sequence_matcher_core.sv
// ----------------------------------------------------------------------------
// key_chord_sequence_matcher_core
// key chain binding table with newest-first prefix matching of pressed keys
//
// channel   direction   handshake                     payload
// item      in          item_valid / item_stall       mode .. command_id
// result    out         result_valid / result_stall   status .. entry_count
//
// one item at a time, one result per item
// key press: scans the bindings newest first, one table read per cycle through the memory port
// add: writes the new binding at the end of the table; remove: scans from the newest
//   end for the match, then moves each later binding down one place by a read and a write
// reset empties the table through its entry count, no clearing pass
// a result waits in the output register under stall; the next item is accepted
//   meanwhile and its result is held back until that register frees
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_chord_sequence_matcher_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int CHAIN_MAX   = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [kcsm_pkg::MODE_W-1:0]         mode,
    input  logic [kcsm_pkg::LEN_W-1:0]          chain_len,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_0,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_0,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_1,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_1,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_2,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_2,
    input  logic [kcsm_pkg::CMD_W-1:0]          command_id,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [kcsm_pkg::STATUS_W-1:0]       status,
    output logic [kcsm_pkg::CMD_W-1:0]          fired_command,
    output logic [kcsm_pkg::LEN_W-1:0]          pressed_count,
    output logic [kcsm_pkg::COUNT_W-1:0]        entry_count
);

    kcsm_pkg::dp_cmd_t cmd;
    kcsm_pkg::dp_sts_t sts;
    logic              in_xfer;
    logic              out_xfer;

    kcsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    kcsm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CHAIN_MAX   (CHAIN_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .chain_len     (chain_len),
        .key_type_0    (key_type_0),
        .key_code_0    (key_code_0),
        .key_type_1    (key_type_1),
        .key_code_1    (key_code_1),
        .key_type_2    (key_type_2),
        .key_code_2    (key_code_2),
        .command_id    (command_id),
        .cmd           (cmd),
        .sts           (sts),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .fired_command (fired_command),
        .pressed_count (pressed_count),
        .entry_count   (entry_count)
    );

    assign in_xfer  = item_valid && !item_stall;
    assign out_xfer = result_valid && !result_stall;

    `KCSM_ASSERT(a_busy_after_transfer, clk, rst_n, in_xfer |=> item_stall, "item while busy")
    `KCSM_ASSERT(a_no_write_when_full, clk, rst_n, cmd.add_wr |-> !sts.full, "append when full")
    `KCSM_ASSERT(a_result_drops, clk, rst_n, out_xfer && !cmd.post |=> !result_valid, "repeat")
    `KCSM_ASSERT_RST(a_reset_no_result, clk, !rst_n |-> !result_valid, "result valid in reset")

endmodule

### hw/rtl/kcsm_ctrl.sv
// ----------------------------------------------------------------------------
// kcsm_ctrl
// sequencer for add, remove and key press items
// ----------------------------------------------------------------------------
module kcsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  kcsm_pkg::dp_sts_t  sts,
    output kcsm_pkg::dp_cmd_t  cmd
);

    kcsm_pkg::ctrl_state_t state_reg;
    kcsm_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kcsm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != kcsm_pkg::S_IDLE);
        case (state_reg)
            kcsm_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = kcsm_pkg::S_PREP;
                end
            end
            kcsm_pkg::S_PREP:
            begin
                state_next = kcsm_pkg::S_FINISH;
                case (sts.mode)
                    kcsm_pkg::MODE_ADD:
                    begin
                        if (sts.len_ok && !sts.full)
                        begin
                            cmd.add_wr = 1'b1;
                        end
                        else
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = kcsm_pkg::ST_FULL;
                        end
                    end
                    kcsm_pkg::MODE_REMOVE:
                    begin
                        if (sts.len_ok && !sts.empty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = kcsm_pkg::S_SCAN;
                        end
                        else
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = kcsm_pkg::ST_NOTFOUND;
                        end
                    end
                    kcsm_pkg::MODE_KEY:
                    begin
                        cmd.push_key = 1'b1;
                        if (sts.empty)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = kcsm_pkg::ST_NOMATCH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = kcsm_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = kcsm_pkg::ST_NOMATCH;
                    end
                endcase
            end
            kcsm_pkg::S_SCAN:
            begin
                cmd.scan_rd   = !sts.issue_done;
                cmd.scan_eval = 1'b1;
                if (sts.hit)
                begin
                    if (sts.mode == kcsm_pkg::MODE_REMOVE)
                    begin
                        cmd.sh_start = 1'b1;
                        state_next   = kcsm_pkg::S_SH_RD;
                    end
                    else
                    begin
                        state_next = kcsm_pkg::S_FINISH;
                    end
                end
                else if (sts.miss_end)
                begin
                    state_next = kcsm_pkg::S_FINISH;
                end
            end
            kcsm_pkg::S_SH_RD:
            begin
                if (sts.sh_last)
                begin
                    cmd.sh_done = 1'b1;
                    state_next  = kcsm_pkg::S_FINISH;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = kcsm_pkg::S_SH_WR;
                end
            end
            kcsm_pkg::S_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = kcsm_pkg::S_SH_RD;
            end
            kcsm_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = kcsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kcsm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/kcsm_datapath.sv
// ----------------------------------------------------------------------------
// kcsm_datapath
// binding table memory, pending key buffer, matchers and result register
// ----------------------------------------------------------------------------
module kcsm_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int CHAIN_MAX   = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [kcsm_pkg::MODE_W-1:0]         mode,
    input  logic [kcsm_pkg::LEN_W-1:0]          chain_len,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_0,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_0,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_1,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_1,
    input  logic [kcsm_pkg::TYPE_W-1:0]         key_type_2,
    input  logic [kcsm_pkg::CODE_W-1:0]         key_code_2,
    input  logic [kcsm_pkg::CMD_W-1:0]          command_id,
    input  kcsm_pkg::dp_cmd_t                   cmd,
    output kcsm_pkg::dp_sts_t                   sts,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [kcsm_pkg::STATUS_W-1:0]       status,
    output logic [kcsm_pkg::CMD_W-1:0]          fired_command,
    output logic [kcsm_pkg::LEN_W-1:0]          pressed_count,
    output logic [kcsm_pkg::COUNT_W-1:0]        entry_count
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CODES_W = kcsm_pkg::KEY_SLOTS * kcsm_pkg::CODE_W;
    localparam int TYPES_W = kcsm_pkg::KEY_SLOTS * kcsm_pkg::TYPE_W;
    localparam logic [kcsm_pkg::LEN_W-1:0] CHAIN_MAX_L = kcsm_pkg::LEN_W'(CHAIN_MAX);
    localparam logic [CNT_W-1:0]           DEPTH_L     = CNT_W'(TABLE_DEPTH);

    kcsm_pkg::entry_t mem [TABLE_DEPTH];
    kcsm_pkg::entry_t rd_data_reg;

    // latched item
    logic [kcsm_pkg::MODE_W-1:0] item_mode_reg;
    logic [kcsm_pkg::LEN_W-1:0]  item_len_reg;
    logic [CODES_W-1:0]          item_codes_reg;
    logic [TYPES_W-1:0]          item_types_reg;
    logic [kcsm_pkg::CMD_W-1:0]  item_cmd_reg;
    logic [CODES_W-1:0]          ld_codes;
    logic [TYPES_W-1:0]          ld_types;

    // table and pending state
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CODES_W-1:0]          pend_codes_reg;
    logic [CODES_W-1:0]          pend_codes_next;
    logic [TYPES_W-1:0]          pend_types_reg;
    logic [TYPES_W-1:0]          pend_types_next;
    logic [kcsm_pkg::LEN_W-1:0]  pend_len_reg;
    logic [kcsm_pkg::LEN_W-1:0]  pend_len_next;

    // scan and shift control
    logic [IDX_W-1:0]            rd_idx_reg;
    logic [IDX_W-1:0]            rd_idx_next;
    logic                        issue_done_reg;
    logic                        issue_done_next;
    logic                        cmp_vld_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic [CNT_W-1:0]            sh_idx_reg;
    logic [CNT_W-1:0]            sh_idx_next;
    logic [CNT_W-1:0]            sh_p1;
    logic [CNT_W-1:0]            cnt_m1;

    // working and output results
    logic [kcsm_pkg::STATUS_W-1:0] res_status_reg;
    logic [kcsm_pkg::STATUS_W-1:0] res_status_next;
    logic [kcsm_pkg::CMD_W-1:0]    res_fired_reg;
    logic [kcsm_pkg::CMD_W-1:0]    res_fired_next;
    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic [kcsm_pkg::STATUS_W-1:0] out_status_reg;
    logic [kcsm_pkg::CMD_W-1:0]    out_fired_reg;
    logic [kcsm_pkg::LEN_W-1:0]    out_pressed_reg;
    logic [kcsm_pkg::COUNT_W-1:0]  out_entries_reg;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    kcsm_pkg::entry_t              wr_data;
    logic [IDX_W-1:0]              rd_addr;
    kcsm_pkg::entry_t              new_entry;

    logic [CODES_W-1:0]            cmask;
    logic [TYPES_W-1:0]            tmask;
    logic                          key_match;
    logic                          rm_match;
    logic                          match;
    logic                          pend_ovf;
    logic                          pend_clr;
    logic [CODES_W-1:0]            base_codes;
    logic [TYPES_W-1:0]            base_types;
    logic [kcsm_pkg::LEN_W-1:0]    base_len;

    // unused key slots are stored as zero
    always_comb
    begin
        ld_codes = '0;
        ld_types = '0;
        ld_codes[0 +: kcsm_pkg::CODE_W] = key_code_0;
        ld_types[0 +: kcsm_pkg::TYPE_W] = key_type_0;
        if (chain_len >= 2'd2)
        begin
            ld_codes[kcsm_pkg::CODE_W +: kcsm_pkg::CODE_W] = key_code_1;
            ld_types[kcsm_pkg::TYPE_W +: kcsm_pkg::TYPE_W] = key_type_1;
        end
        if (chain_len == 2'd3)
        begin
            ld_codes[2*kcsm_pkg::CODE_W +: kcsm_pkg::CODE_W] = key_code_2;
            ld_types[2*kcsm_pkg::TYPE_W +: kcsm_pkg::TYPE_W] = key_type_2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_mode_reg  <= mode;
            item_len_reg   <= chain_len;
            item_codes_reg <= ld_codes;
            item_types_reg <= ld_types;
            item_cmd_reg   <= command_id;
        end
    end

    // prefix masks for the pending length
    always_comb
    begin
        cmask = '0;
        tmask = '0;
        for (int s = 0; s < kcsm_pkg::KEY_SLOTS; s++)
        begin
            if (kcsm_pkg::LEN_W'(s) < pend_len_reg)
            begin
                cmask[s*kcsm_pkg::CODE_W +: kcsm_pkg::CODE_W] = '1;
                tmask[s*kcsm_pkg::TYPE_W +: kcsm_pkg::TYPE_W] = '1;
            end
        end
    end

    assign key_match = (rd_data_reg.len >= pend_len_reg)
                    && ((rd_data_reg.codes & cmask) == pend_codes_reg)
                    && ((rd_data_reg.types & tmask) == pend_types_reg);
    assign rm_match  = (rd_data_reg.codes == item_codes_reg)
                    && (rd_data_reg.types == item_types_reg)
                    && (rd_data_reg.len == item_len_reg);
    assign match     = (item_mode_reg == kcsm_pkg::MODE_REMOVE) ? rm_match : key_match;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign sh_p1  = sh_idx_reg + CNT_W'(1);

    // memory ports
    assign new_entry.cmd_id = item_cmd_reg;
    assign new_entry.len    = item_len_reg;
    assign new_entry.types  = item_types_reg;
    assign new_entry.codes  = item_codes_reg;
    assign wr_en   = cmd.add_wr || cmd.sh_wr;
    assign wr_addr = cmd.add_wr ? count_reg[IDX_W-1:0] : sh_idx_reg[IDX_W-1:0];
    assign wr_data = cmd.add_wr ? new_entry : rd_data_reg;
    assign rd_addr = cmd.sh_rd ? sh_p1[IDX_W-1:0] : rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // pending key buffer
    assign pend_ovf   = (pend_len_reg >= CHAIN_MAX_L);
    assign base_codes = pend_ovf ? '0 : pend_codes_reg;
    assign base_types = pend_ovf ? '0 : pend_types_reg;
    assign base_len   = pend_ovf ? '0 : pend_len_reg;
    assign pend_clr   = (item_mode_reg == kcsm_pkg::MODE_KEY)
                     && (res_status_reg != kcsm_pkg::ST_PENDING);

    always_comb
    begin
        pend_codes_next = pend_codes_reg;
        pend_types_next = pend_types_reg;
        pend_len_next   = pend_len_reg;
        if (cmd.push_key)
        begin
            pend_codes_next = base_codes;
            pend_types_next = base_types;
            pend_len_next   = base_len + 2'd1;
            case (base_len)
                2'd0:
                begin
                    pend_codes_next[0 +: kcsm_pkg::CODE_W] = item_codes_reg[0 +: kcsm_pkg::CODE_W];
                    pend_types_next[0 +: kcsm_pkg::TYPE_W] = item_types_reg[0 +: kcsm_pkg::TYPE_W];
                end
                2'd1:
                begin
                    pend_codes_next[kcsm_pkg::CODE_W +: kcsm_pkg::CODE_W] =
                        item_codes_reg[0 +: kcsm_pkg::CODE_W];
                    pend_types_next[kcsm_pkg::TYPE_W +: kcsm_pkg::TYPE_W] =
                        item_types_reg[0 +: kcsm_pkg::TYPE_W];
                end
                2'd2:
                begin
                    pend_codes_next[2*kcsm_pkg::CODE_W +: kcsm_pkg::CODE_W] =
                        item_codes_reg[0 +: kcsm_pkg::CODE_W];
                    pend_types_next[2*kcsm_pkg::TYPE_W +: kcsm_pkg::TYPE_W] =
                        item_types_reg[0 +: kcsm_pkg::TYPE_W];
                end
                default:
                begin
                    pend_len_next = pend_len_reg;
                end
            endcase
        end
        else if (cmd.post && pend_clr)
        begin
            pend_codes_next = '0;
            pend_types_next = '0;
            pend_len_next   = '0;
        end
    end

    // scan, shift, count and results
    always_comb
    begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        sh_idx_next     = sh_idx_reg;
        res_status_next = res_status_reg;
        res_fired_next  = res_fired_reg;
        out_vld_next    = out_vld_reg && result_stall;
        if (cmd.load)
        begin
            res_status_next = kcsm_pkg::ST_NOMATCH;
            res_fired_next  = '0;
        end
        if (cmd.set_st)
        begin
            res_status_next = cmd.st;
        end
        if (cmd.add_wr)
        begin
            count_next      = count_reg + CNT_W'(1);
            res_status_next = kcsm_pkg::ST_ADDED;
        end
        if (cmd.scan_start)
        begin
            rd_idx_next     = cnt_m1[IDX_W-1:0];
            issue_done_next = 1'b0;
        end
        if (cmd.scan_rd)
        begin
            if (rd_idx_reg == '0)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                rd_idx_next = rd_idx_reg - IDX_W'(1);
            end
        end
        if (cmd.scan_eval && sts.hit)
        begin
            if (item_mode_reg == kcsm_pkg::MODE_REMOVE)
            begin
                res_status_next = kcsm_pkg::ST_REMOVED;
            end
            else if (rd_data_reg.len > pend_len_reg)
            begin
                res_status_next = kcsm_pkg::ST_PENDING;
            end
            else
            begin
                res_status_next = kcsm_pkg::ST_FIRED;
                res_fired_next  = rd_data_reg.cmd_id;
            end
        end
        else if (cmd.scan_eval && sts.miss_end)
        begin
            res_status_next = (item_mode_reg == kcsm_pkg::MODE_REMOVE) ?
                              kcsm_pkg::ST_NOTFOUND : kcsm_pkg::ST_NOMATCH;
        end
        if (cmd.sh_start)
        begin
            sh_idx_next = CNT_W'(cmp_idx_reg);
        end
        if (cmd.sh_wr)
        begin
            sh_idx_next = sh_p1;
        end
        if (cmd.sh_done)
        begin
            count_next = cnt_m1;
        end
        if (cmd.post)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_codes_reg <= '0;
            pend_types_reg <= '0;
            pend_len_reg   <= '0;
            issue_done_reg <= 1'b1;
            cmp_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_codes_reg <= pend_codes_next;
            pend_types_reg <= pend_types_next;
            pend_len_reg   <= pend_len_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmd.scan_rd;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        sh_idx_reg     <= sh_idx_next;
        res_status_reg <= res_status_next;
        res_fired_reg  <= res_fired_next;
        if (cmd.scan_rd)
        begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.post)
        begin
            out_status_reg  <= res_status_reg;
            out_fired_reg   <= res_fired_reg;
            out_pressed_reg <= pend_clr ? '0 : pend_len_reg;
            out_entries_reg <= kcsm_pkg::COUNT_W'(count_reg);
        end
    end

    assign sts.mode       = item_mode_reg;
    assign sts.len_ok     = (item_len_reg != '0) && (item_len_reg <= CHAIN_MAX_L);
    assign sts.full       = (count_reg >= DEPTH_L);
    assign sts.empty      = (count_reg == '0);
    assign sts.issue_done = issue_done_reg;
    assign sts.hit        = cmp_vld_reg && match;
    assign sts.miss_end   = cmp_vld_reg && !match && (cmp_idx_reg == '0);
    assign sts.sh_last    = (sh_p1 >= count_reg);
    assign sts.out_free   = !out_vld_reg || !result_stall;

    assign result_valid  = out_vld_reg;
    assign status        = out_status_reg;
    assign fired_command = out_fired_reg;
    assign pressed_count = out_pressed_reg;
    assign entry_count   = out_entries_reg;

endmodule
